/* design/button_debounce_long_press_repeat_defines.svh */
// ----------------------------------------------------------------------------
// button debounce assertion macros
// shared concurrent assertion forms for the debouncer modules
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_DEFINES_SVH

// clocked property, disabled while reset is asserted
`define BDLP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bdlp assertion failed");

// same form with a caller supplied message
`define BDLP_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

/* design/bdlp_pkg.sv */
// ----------------------------------------------------------------------------
// bdlp_pkg
// types and constants shared by the button debouncer modules
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int unsigned DebW  = 8;
  localparam int unsigned TickW = 16;
  localparam int unsigned IdxW  = 2;
  localparam int unsigned DataW = 16;

  // configuration register indexes
  localparam logic [IdxW-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [IdxW-1:0] REG_LONG     = 2'd1;
  localparam logic [IdxW-1:0] REG_REPEAT   = 2'd2;

  // reset values of the configuration registers
  localparam logic [DebW-1:0]  DEBOUNCE_RST = 8'd5;
  localparam logic [TickW-1:0] LONG_RST     = 16'd100;
  localparam logic [TickW-1:0] REPEAT_RST   = 16'd20;

  typedef enum logic [1:0] {
    EV_SHORT   = 2'd0,
    EV_LONG    = 2'd1,
    EV_RELEASE = 2'd2
  } event_e;

  typedef struct packed {
    logic [DebW-1:0]  debounce_ticks;
    logic [TickW-1:0] long_press_ticks;
    logic [TickW-1:0] repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic   vld;
    event_e code;
  } res_t;

endpackage

/* design/button_debounce_long_press_repeat.sv */
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat
// one-button debouncer with short press, long press, auto repeat and release
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_stall_o    raw_level_i (0 = pressed)
//   out      source     out_valid_o/out_stall_i  event_code_o
//   cfg      sink       cfg_we_i                 cfg_idx_i, cfg_data_i
//
// one sample per cycle sustained unless the output stalls; a sample is taken into
// the sample register at acceptance and its event passes on to the result register.
// reset puts the registers at debounce 5, long press 100, repeat 20, released.
// a stalled output holds its beat; the input stalls only when a sample waits
// behind a full result register that is itself stalled.
// ----------------------------------------------------------------------------
module button_debounce_long_press_repeat (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bdlp_pkg::IdxW-1:0]   cfg_idx_i,
  input  logic [bdlp_pkg::DataW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        raw_level_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  event_code_o
);
  import bdlp_pkg::*;

  cfg_t cfg;
  res_t res;
  logic slot_free;

  // configuration registers
  bdlp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // sample register and state update
  bdlp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .raw_level_i (raw_level_i),
    .slot_free_i (slot_free),
    .res_o       (res)
  );

  // result register
  bdlp_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_i        (res),
    .slot_free_o  (slot_free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_code_o (event_code_o)
  );

endmodule

/* design/bdlp_cfg.sv */
// ----------------------------------------------------------------------------
// bdlp_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module bdlp_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bdlp_pkg::IdxW-1:0]   cfg_idx_i,
  input  logic [bdlp_pkg::DataW-1:0]  cfg_data_i,
  output bdlp_pkg::cfg_t              cfg_o
);
  import bdlp_pkg::*;

  cfg_t cfg_q;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= DEBOUNCE_RST;
      cfg_q.long_press_ticks <= LONG_RST;
      cfg_q.repeat_ticks     <= REPEAT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE: cfg_q.debounce_ticks   <= cfg_data_i[DebW-1:0];
        REG_LONG:     cfg_q.long_press_ticks <= cfg_data_i[TickW-1:0];
        REG_REPEAT:   cfg_q.repeat_ticks     <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/bdlp_core.sv */
// ----------------------------------------------------------------------------
// bdlp_core
// sample register and debounce / hold / repeat state update
// ----------------------------------------------------------------------------
`include "button_debounce_long_press_repeat_defines.svh"

module bdlp_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bdlp_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            raw_level_i,
  input  logic            slot_free_i,
  output bdlp_pkg::res_t  res_o
);
  import bdlp_pkg::*;

  logic             in_vld_q;
  logic             raw_q;
  logic             step;

  logic             pressed_q, pressed_d;
  logic [DebW-1:0]  pcnt_q, pcnt_d;
  logic [DebW-1:0]  rcnt_q, rcnt_d;
  logic [TickW-1:0] hold_q, hold_d;
  logic             lfired_q, lfired_d;
  logic [TickW-1:0] rep_q, rep_d;

  logic             down;
  logic [DebW-1:0]  pcnt_inc, rcnt_inc;
  logic [TickW-1:0] hold_inc, rep_inc;
  logic             ev_vld;
  event_e           ev_code;

  // sample register, held while the result slot is busy
  assign step       = in_vld_q & slot_free_i;
  assign in_stall_o = in_vld_q & ~slot_free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      raw_q <= raw_level_i;
    end
  end

  // saturating increments
  assign down     = ~raw_q;
  assign pcnt_inc = (pcnt_q == '1) ? pcnt_q : pcnt_q + DebW'(1);
  assign rcnt_inc = (rcnt_q == '1) ? rcnt_q : rcnt_q + DebW'(1);
  assign hold_inc = (hold_q == '1) ? hold_q : hold_q + TickW'(1);
  assign rep_inc  = (rep_q == '1) ? rep_q : rep_q + TickW'(1);

  // next state and event for one sample
  always_comb begin
    pressed_d = pressed_q;
    pcnt_d    = pcnt_q;
    rcnt_d    = rcnt_q;
    hold_d    = hold_q;
    lfired_d  = lfired_q;
    rep_d     = rep_q;
    ev_vld    = 1'b0;
    ev_code   = EV_SHORT;
    case ({down, pressed_q})
      // press debounce
      2'b10: begin
        if (pcnt_inc >= cfg_i.debounce_ticks) begin
          pressed_d = 1'b1;
          hold_d    = '0;
          lfired_d  = 1'b0;
          rep_d     = '0;
          pcnt_d    = '0;
          rcnt_d    = '0;
          ev_vld    = 1'b1;
          ev_code   = EV_SHORT;
        end else begin
          pcnt_d = pcnt_inc;
        end
      end
      // held: long press, then auto repeat
      2'b11: begin
        hold_d = hold_inc;
        rep_d  = rep_inc;
        if (!lfired_q && hold_inc >= cfg_i.long_press_ticks) begin
          lfired_d = 1'b1;
          rep_d    = '0;
          ev_vld   = 1'b1;
          ev_code  = EV_LONG;
        end else if (lfired_q && rep_inc >= cfg_i.repeat_ticks) begin
          rep_d   = '0;
          ev_vld  = 1'b1;
          ev_code = EV_SHORT;
        end
      end
      // release debounce, counts across bounces
      2'b01: begin
        if (rcnt_inc >= cfg_i.debounce_ticks) begin
          pressed_d = 1'b0;
          pcnt_d    = '0;
          rcnt_d    = '0;
          rep_d     = '0;
          ev_vld    = 1'b1;
          ev_code   = EV_RELEASE;
        end else begin
          rcnt_d = rcnt_inc;
        end
      end
      // idle and unpressed
      default: begin
        pcnt_d = '0;
        rcnt_d = '0;
        rep_d  = '0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= 1'b0;
      pcnt_q    <= '0;
      rcnt_q    <= '0;
      hold_q    <= '0;
      lfired_q  <= 1'b0;
      rep_q     <= '0;
    end else if (step) begin
      pressed_q <= pressed_d;
      pcnt_q    <= pcnt_d;
      rcnt_q    <= rcnt_d;
      hold_q    <= hold_d;
      lfired_q  <= lfired_d;
      rep_q     <= rep_d;
    end
  end

  assign res_o.vld  = step & ev_vld;
  assign res_o.code = ev_code;

  // checks
  `BDLP_ASSERT(a_press_cnt_idle, clk_i, rst_ni, (pcnt_q != '0) |-> !pressed_q)
  `BDLP_ASSERT(a_rel_cnt_held, clk_i, rst_ni, (rcnt_q != '0) |-> pressed_q)
  `BDLP_ASSERT_MSG(a_rel_event, clk_i, rst_ni, $fell(pressed_q) |-> ($past(res_o.vld) && ($past(res_o.code) == EV_RELEASE)), "press dropped without release event")
  `BDLP_ASSERT_MSG(a_long_once, clk_i, rst_ni, (res_o.vld && (res_o.code == EV_LONG)) |-> !lfired_q, "second long press event")

endmodule

/* design/bdlp_out.sv */
// ----------------------------------------------------------------------------
// bdlp_out
// result register towards the output channel
// ----------------------------------------------------------------------------
module bdlp_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bdlp_pkg::res_t  res_i,
  output logic            slot_free_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      event_code_o
);
  import bdlp_pkg::*;

  logic   out_vld_q;
  event_e code_q;

  // slot frees when empty or when the held beat leaves
  assign slot_free_o = ~out_vld_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (slot_free_o) begin
      out_vld_q <= res_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free_o && res_i.vld) begin
      code_q <= res_i.code;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign event_code_o = code_q;

endmodule
